>>> src/quartic_root_finder_macros.svh
// Assertion macros for the quartic root finder checkers.
// Expect signals named clk and rst in the scope of use.
`ifndef QUARTIC_ROOT_FINDER_MACROS_SVH
`define QUARTIC_ROOT_FINDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/qrf_pkg.sv
// Types, codes and saturating helpers for the quartic root finder.
// No dependencies; used by qrf_arith, quartic_root_finder and qrf_checker.
`default_nettype none

package qrf_pkg;

  localparam int QW = 48;
  localparam int MW = 97;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam q_t QMIN = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    K_EST    = 3'd0,
    K_CONV   = 3'd1,
    K_LIMIT  = 3'd2,
    K_DIVZ   = 3'd3,
    K_NOSOL  = 3'd4,
    K_NOCONV = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    M_NONE   = 2'd0,
    M_BISECT = 2'd1,
    M_NEWTON = 2'd2,
    M_SECANT = 2'd3
  } meth_t;

  typedef enum logic [1:0] {
    CFG_METHOD    = 2'd0,
    CFG_PRECISION = 2'd1
  } cfg_t;

  typedef enum logic [1:0] {
    OP_QMUL = 2'd0,
    OP_IMUL = 2'd1,
    OP_DIV  = 2'd2
  } aop_t;

  typedef struct packed {
    logic start;
    aop_t op;
  } areq_t;

  typedef enum logic [1:0] {
    A_IDLE = 2'd0,
    A_MUL  = 2'd1,
    A_DIV  = 2'd2,
    A_FIN  = 2'd3
  } ast_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_ITER, ST_CALL, ST_WAIT,
    ST_POW2, ST_POW3, ST_POW4, ST_TERM, ST_SCALE, ST_ACC,
    ST_UPDATE, ST_NDIV, ST_SMUL, ST_SDIV,
    ST_AG0, ST_AG1, ST_AG2, ST_NEXT, ST_EMIT
  } st_t;

  function automatic logic [QW-1:0] mag(input q_t v);
    mag = v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  function automatic q_t sat_mag(input logic neg, input logic [MW-1:0] mg);
    if (neg) begin
      if (mg > MW'(48'h8000_0000_0000)) sat_mag = QMIN;
      else sat_mag = q_t'(-mg[QW-1:0]);
    end else begin
      if (mg > MW'(48'h7FFF_FFFF_FFFF)) sat_mag = QMAX;
      else sat_mag = q_t'(mg[QW-1:0]);
    end
  endfunction

  function automatic q_t sat_add(input q_t x, input q_t y);
    logic [QW:0] s;
    s = {x[QW-1], x} + {y[QW-1], y};
    if (s[QW] != s[QW-1]) sat_add = s[QW] ? QMIN : QMAX;
    else sat_add = q_t'(s[QW-1:0]);
  endfunction

  function automatic q_t sat_sub(input q_t x, input q_t y);
    logic [QW:0] s;
    s = {x[QW-1], x} - {y[QW-1], y};
    if (s[QW] != s[QW-1]) sat_sub = s[QW] ? QMIN : QMAX;
    else sat_sub = q_t'(s[QW-1:0]);
  endfunction

  // Decimal scale for the stop test, precision already clamped to nine.
  function automatic q_t pow10(input logic [3:0] pr);
    case (pr)
      4'd0:    pow10 = 48'sd1;
      4'd1:    pow10 = 48'sd10;
      4'd2:    pow10 = 48'sd100;
      4'd3:    pow10 = 48'sd1000;
      4'd4:    pow10 = 48'sd10000;
      4'd5:    pow10 = 48'sd100000;
      4'd6:    pow10 = 48'sd1000000;
      4'd7:    pow10 = 48'sd10000000;
      4'd8:    pow10 = 48'sd100000000;
      default: pow10 = 48'sd1000000000;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> src/quartic_root_finder.sv
// Quartic root finder: top level with sequencer, output register and config.
// Depends on qrf_pkg and qrf_arith.
//
// Usage:
//  - Configure through cfg_valid/cfg_index/cfg_data while idle: index 0 is
//    the method (1 bisection, 2 Newton, 3 secant), index 1 the precision in
//    decimal digits. cfg_ready is always high; unknown indexes are dropped.
//  - A request on s_* carries five 16-bit coefficients. s_tready is high only
//    while no run is in progress; one request is worked at a time.
//  - Each run returns zero or more estimates (m_tuser = 0), then one final item
//    with m_tlast high whose m_tuser gives the outcome.
//  - All arithmetic runs through one shared multiply / divide unit; a run
//    takes up to MAX_ITER iterations. Trivial cases answer without iterating.
//  - One output register holds a result; while m_tready is low the sequencer
//    holds at its next result and resumes once the register drains.
//  - Synchronous reset returns to idle, drops the output register and sets
//    method to bisection and precision to six.
`default_nettype none

module quartic_root_finder #(
  parameter int MAX_ITER  = 50,
  parameter int FRAC_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // coef_0, coef_1, coef_2, coef_3, coef_4
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // x_value, iteration, zero pad
  output logic [2:0]       m_tuser,   // kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  localparam qrf_pkg::q_t ONE  = qrf_pkg::q_t'(64'(1) << FRAC_BITS);
  localparam qrf_pkg::q_t HALF = qrf_pkg::q_t'(64'(1) << (FRAC_BITS - 1));

  // configuration registers
  qrf_pkg::meth_t method;
  logic [3:0]     precision;

  qrf_pkg::st_t   state, state_next, ret, ret_next;
  logic signed [15:0] coef [5];
  qrf_pkg::meth_t meth, meth_next;
  logic [3:0]     pr, pr_next;
  qrf_pkg::q_t    a, a_next, b, b_next, m, m_next;
  qrf_pkg::q_t    fa, fa_next, fm, fm_next, ex, ex_next, acc, acc_next;
  qrf_pkg::q_t    p2, p2_next, p3, p3_next, p4, p4_next;
  qrf_pkg::q_t    opa, opa_next, opb, opb_next;
  qrf_pkg::aop_t  op, op_next;
  logic [2:0]     kidx, kidx_next;
  logic           phase, phase_next, dmode, dmode_next;
  logic [5:0]     iter, iter_next;
  qrf_pkg::kind_t pk, pk_next;
  qrf_pkg::q_t    px, px_next;
  logic [5:0]     pi, pi_next;
  logic           pl, pl_next;

  logic           out_valid, out_valid_next, out_load;
  qrf_pkg::kind_t out_kind;
  qrf_pkg::q_t    out_x;
  logic [5:0]     out_iter;
  logic           out_last;

  qrf_pkg::areq_t areq;
  logic           done;
  qrf_pkg::q_t    res;

  qrf_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (areq),
    .opa  (opa),
    .opb  (opb),
    .done (done),
    .res  (res)
  );

  assign s_tready  = (state == qrf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {2'b00, out_iter, out_x};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      method    <= qrf_pkg::M_BISECT;
      precision <= 4'd6;
    end else if (cfg_valid) begin
      case (cfg_index)
        qrf_pkg::CFG_METHOD:    method <= qrf_pkg::meth_t'(cfg_data[1:0]);
        qrf_pkg::CFG_PRECISION: precision <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qrf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret   <= ret_next;
    meth  <= meth_next;
    pr    <= pr_next;
    a     <= a_next;
    b     <= b_next;
    m     <= m_next;
    fa    <= fa_next;
    fm    <= fm_next;
    ex    <= ex_next;
    acc   <= acc_next;
    p2    <= p2_next;
    p3    <= p3_next;
    p4    <= p4_next;
    opa   <= opa_next;
    opb   <= opb_next;
    op    <= op_next;
    kidx  <= kidx_next;
    phase <= phase_next;
    dmode <= dmode_next;
    iter  <= iter_next;
    pk    <= pk_next;
    px    <= px_next;
    pi    <= pi_next;
    pl    <= pl_next;
    if (s_tvalid && s_tready) begin
      coef[0] <= s_tdata[15:0];
      coef[1] <= s_tdata[31:16];
      coef[2] <= s_tdata[47:32];
      coef[3] <= s_tdata[63:48];
      coef[4] <= s_tdata[79:64];
    end
    if (out_load) begin
      out_kind <= pk;
      out_x    <= px;
      out_iter <= pi;
      out_last <= pl;
    end
  end

  always_comb begin
    logic [2:0]  pidx;
    qrf_pkg::q_t xsel, base, dif, sum;
    logic [48:0] hsum, hadj;

    state_next = state;
    ret_next   = ret;
    meth_next  = meth;
    pr_next    = pr;
    a_next     = a;
    b_next     = b;
    m_next     = m;
    fa_next    = fa;
    fm_next    = fm;
    ex_next    = ex;
    acc_next   = acc;
    p2_next    = p2;
    p3_next    = p3;
    p4_next    = p4;
    opa_next   = opa;
    opb_next   = opb;
    op_next    = op;
    kidx_next  = kidx;
    phase_next = phase;
    dmode_next = dmode;
    iter_next  = iter;
    pk_next    = pk;
    px_next    = px;
    pi_next    = pi;
    pl_next    = pl;
    areq.start = 1'b0;
    areq.op    = op;
    out_load   = 1'b0;

    pidx = dmode ? (kidx - 3'd1) : kidx;
    case (pidx)
      3'd0:    base = ONE;
      3'd1:    base = ex;
      3'd2:    base = p2;
      3'd3:    base = p3;
      default: base = p4;
    endcase
    xsel = (meth == qrf_pkg::M_NEWTON) ? m : a;
    dif  = qrf_pkg::sat_sub(fm, fa);
    sum  = qrf_pkg::sat_add(acc, res);
    hsum = {a[47], a} + {b[47], b};
    hadj = hsum + {48'd0, hsum[48]};

    case (state)
      qrf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          a_next     = '0;
          b_next     = ONE;
          m_next     = HALF;
          iter_next  = 6'd1;
          meth_next  = (method == qrf_pkg::M_NONE) ? qrf_pkg::M_BISECT : method;
          pr_next    = (precision > 4'd9) ? 4'd9 : precision;
          state_next = qrf_pkg::ST_CHECK;
        end
      end

      qrf_pkg::ST_CHECK: begin
        pi_next  = '0;
        pl_next  = 1'b1;
        ret_next = qrf_pkg::ST_IDLE;
        if (coef[2] == 16'sd0 && coef[3] == 16'sd0 && coef[4] == 16'sd0) begin
          // linear or constant: answer at once
          pk_next    = (coef[1] == 16'sd0) ? qrf_pkg::K_NOSOL : qrf_pkg::K_CONV;
          px_next    = (coef[1] == 16'sd0) ? '0 : HALF;
          state_next = qrf_pkg::ST_EMIT;
        end else if (meth == qrf_pkg::M_SECANT && coef[4] > 16'sd10) begin
          pk_next    = qrf_pkg::K_NOCONV;
          px_next    = '0;
          state_next = qrf_pkg::ST_EMIT;
        end else begin
          state_next = qrf_pkg::ST_ITER;
        end
      end

      qrf_pkg::ST_ITER: begin
        // first evaluation of the iteration: f(a), or f(m) for Newton
        phase_next = 1'b0;
        dmode_next = 1'b0;
        ex_next    = xsel;
        op_next    = qrf_pkg::OP_QMUL;
        opa_next   = xsel;
        opb_next   = xsel;
        ret_next   = qrf_pkg::ST_POW2;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_CALL: begin
        areq.start = 1'b1;
        state_next = qrf_pkg::ST_WAIT;
      end

      qrf_pkg::ST_WAIT: begin
        if (done) state_next = ret;
      end

      qrf_pkg::ST_POW2: begin
        p2_next    = res;
        opa_next   = res;
        opb_next   = ex;
        op_next    = qrf_pkg::OP_QMUL;
        ret_next   = qrf_pkg::ST_POW3;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_POW3: begin
        p3_next    = res;
        opa_next   = res;
        opb_next   = ex;
        op_next    = qrf_pkg::OP_QMUL;
        ret_next   = qrf_pkg::ST_POW4;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_POW4: begin
        p4_next    = res;
        acc_next   = '0;
        kidx_next  = 3'd4;
        state_next = qrf_pkg::ST_TERM;
      end

      qrf_pkg::ST_TERM: begin
        // coefficient times power, highest degree first
        opa_next   = {{32{coef[kidx][15]}}, coef[kidx]};
        opb_next   = base;
        op_next    = qrf_pkg::OP_IMUL;
        ret_next   = dmode ? qrf_pkg::ST_SCALE : qrf_pkg::ST_ACC;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_SCALE: begin
        opa_next   = res;
        opb_next   = {45'd0, kidx};
        op_next    = qrf_pkg::OP_IMUL;
        ret_next   = qrf_pkg::ST_ACC;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_ACC: begin
        acc_next = sum;
        if (kidx == {2'b00, dmode}) begin
          if (!phase) begin
            // second evaluation: f(m), f'(m) for Newton, f(b) for secant
            fa_next    = sum;
            phase_next = 1'b1;
            dmode_next = (meth == qrf_pkg::M_NEWTON);
            ex_next    = (meth == qrf_pkg::M_SECANT) ? b : m;
            opa_next   = (meth == qrf_pkg::M_SECANT) ? b : m;
            opb_next   = (meth == qrf_pkg::M_SECANT) ? b : m;
            op_next    = qrf_pkg::OP_QMUL;
            ret_next   = qrf_pkg::ST_POW2;
            state_next = qrf_pkg::ST_CALL;
          end else begin
            fm_next    = sum;
            state_next = qrf_pkg::ST_UPDATE;
          end
        end else begin
          kidx_next  = kidx - 3'd1;
          state_next = qrf_pkg::ST_TERM;
        end
      end

      qrf_pkg::ST_UPDATE: begin
        case (meth)
          qrf_pkg::M_NEWTON: begin
            if (fm == '0) begin
              pk_next    = qrf_pkg::K_DIVZ;
              px_next    = m;
              pi_next    = iter;
              pl_next    = 1'b1;
              ret_next   = qrf_pkg::ST_IDLE;
              state_next = qrf_pkg::ST_EMIT;
            end else begin
              opa_next   = fa;
              opb_next   = fm;
              op_next    = qrf_pkg::OP_DIV;
              ret_next   = qrf_pkg::ST_NDIV;
              state_next = qrf_pkg::ST_CALL;
            end
          end
          qrf_pkg::M_SECANT: begin
            if (dif == '0) begin
              pk_next    = qrf_pkg::K_DIVZ;
              px_next    = m;
              pi_next    = iter;
              pl_next    = 1'b1;
              ret_next   = qrf_pkg::ST_IDLE;
              state_next = qrf_pkg::ST_EMIT;
            end else begin
              // keep the denominator in fa for the divide
              fa_next    = dif;
              opa_next   = fm;
              opb_next   = qrf_pkg::sat_sub(b, a);
              op_next    = qrf_pkg::OP_QMUL;
              ret_next   = qrf_pkg::ST_SMUL;
              state_next = qrf_pkg::ST_CALL;
            end
          end
          default: begin
            // strictly opposite signs move the high end, else the low end
            if ((fa[47] && fm != '0 && !fm[47]) || (!fa[47] && fa != '0 && fm[47]))
              b_next = m;
            else
              a_next = m;
            pk_next    = qrf_pkg::K_EST;
            px_next    = m;
            pi_next    = iter;
            pl_next    = 1'b0;
            ret_next   = qrf_pkg::ST_AG0;
            state_next = qrf_pkg::ST_EMIT;
          end
        endcase
      end

      qrf_pkg::ST_NDIV: begin
        a_next     = qrf_pkg::sat_sub(m, res);
        pk_next    = qrf_pkg::K_EST;
        px_next    = m;
        pi_next    = iter;
        pl_next    = 1'b0;
        ret_next   = qrf_pkg::ST_AG0;
        state_next = qrf_pkg::ST_EMIT;
      end

      qrf_pkg::ST_SMUL: begin
        opa_next   = res;
        opb_next   = fa;
        op_next    = qrf_pkg::OP_DIV;
        ret_next   = qrf_pkg::ST_SDIV;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_SDIV: begin
        m_next     = qrf_pkg::sat_sub(b, res);
        a_next     = b;
        b_next     = qrf_pkg::sat_sub(b, res);
        state_next = qrf_pkg::ST_AG0;
      end

      qrf_pkg::ST_AG0: begin
        // scale both points by 10^precision, rounded
        opa_next   = a;
        opb_next   = qrf_pkg::pow10(pr);
        op_next    = qrf_pkg::OP_QMUL;
        ret_next   = qrf_pkg::ST_AG1;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_AG1: begin
        acc_next   = res;
        opa_next   = (meth == qrf_pkg::M_NEWTON) ? m : b;
        opb_next   = qrf_pkg::pow10(pr);
        op_next    = qrf_pkg::OP_QMUL;
        ret_next   = qrf_pkg::ST_AG2;
        state_next = qrf_pkg::ST_CALL;
      end

      qrf_pkg::ST_AG2: begin
        if (acc == res) begin
          pk_next    = qrf_pkg::K_CONV;
          px_next    = m;
          pi_next    = iter;
          pl_next    = 1'b1;
          ret_next   = qrf_pkg::ST_IDLE;
          state_next = qrf_pkg::ST_EMIT;
        end else begin
          case (meth)
            qrf_pkg::M_NEWTON: begin
              m_next     = a;
              state_next = qrf_pkg::ST_NEXT;
            end
            qrf_pkg::M_SECANT: begin
              pk_next    = qrf_pkg::K_EST;
              px_next    = m;
              pi_next    = iter;
              pl_next    = 1'b0;
              ret_next   = qrf_pkg::ST_NEXT;
              state_next = qrf_pkg::ST_EMIT;
            end
            default: begin
              // midpoint, halving truncated toward zero
              m_next     = qrf_pkg::q_t'(hadj[48:1]);
              state_next = qrf_pkg::ST_NEXT;
            end
          endcase
        end
      end

      qrf_pkg::ST_NEXT: begin
        if (iter == 6'(MAX_ITER)) begin
          pk_next    = qrf_pkg::K_LIMIT;
          px_next    = m;
          pi_next    = iter;
          pl_next    = 1'b1;
          ret_next   = qrf_pkg::ST_IDLE;
          state_next = qrf_pkg::ST_EMIT;
        end else begin
          iter_next  = iter + 6'd1;
          state_next = qrf_pkg::ST_ITER;
        end
      end

      qrf_pkg::ST_EMIT: begin
        // hold here until the output register is free
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ret;
        end
      end

      default: state_next = qrf_pkg::ST_IDLE;
    endcase

    out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid);
  end

endmodule

`default_nettype wire

>>> src/qrf_arith.sv
// Shared multi-cycle multiply / divide unit of the quartic root finder.
// Depends on qrf_pkg.
`default_nettype none

module qrf_arith #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire qrf_pkg::areq_t req,
  input  wire qrf_pkg::q_t   opa,
  input  wire qrf_pkg::q_t   opb,
  output logic               done,
  output qrf_pkg::q_t        res
);

  localparam int QW  = qrf_pkg::QW;
  localparam int MWL = qrf_pkg::MW;
  localparam int DL  = QW + FRAC_BITS;
  localparam int CW  = $clog2(DL + 1);
  localparam logic [MWL-1:0] HALF = MWL'(1) << (FRAC_BITS - 1);

  qrf_pkg::ast_t ast, ast_next;
  qrf_pkg::aop_t opr;
  logic            neg;
  logic [QW-1:0]   xm, ym, rem, q;
  logic [2*QW-1:0] prod;
  logic [CW-1:0]   cnt;
  logic [DL-1:0]   num;
  logic            over;

  logic [QW:0]     rs, rsub;
  logic            ge, rnd;
  logic [63:0]     pp;
  logic [MWL-1:0]  rq, dmag;
  qrf_pkg::q_t     fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      ast <= qrf_pkg::A_IDLE;
    end else begin
      ast <= ast_next;
    end
  end

  always_comb begin
    ast_next = ast;
    case (ast)
      qrf_pkg::A_IDLE: begin
        if (req.start) ast_next = (req.op == qrf_pkg::OP_DIV) ? qrf_pkg::A_DIV : qrf_pkg::A_MUL;
      end
      qrf_pkg::A_MUL, qrf_pkg::A_DIV: begin
        if (cnt == CW'(1)) ast_next = qrf_pkg::A_FIN;
      end
      qrf_pkg::A_FIN: ast_next = qrf_pkg::A_IDLE;
      default: ast_next = qrf_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    // restoring division, one quotient bit a cycle
    rs   = {rem, num[DL-1]};
    rsub = rs - {1'b0, ym};
    ge   = rs >= {1'b0, ym};
    rnd  = {rem, 1'b0} >= {1'b0, ym};
    // 48 x 16 partial product, top digit of the multiplier first
    pp   = 64'(xm * ym[QW-1:QW-16]);
    if (opr == qrf_pkg::OP_QMUL) rq = ({1'b0, prod} + HALF) >> FRAC_BITS;
    else rq = {1'b0, prod};
    dmag = over ? {MWL{1'b1}} : (MWL'(q) + MWL'(rnd));
    fin  = qrf_pkg::sat_mag(neg, (opr == qrf_pkg::OP_DIV) ? dmag : rq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ast == qrf_pkg::A_FIN);
    end
    case (ast)
      qrf_pkg::A_IDLE: begin
        if (req.start) begin
          opr  <= req.op;
          neg  <= opa[QW-1] ^ opb[QW-1];
          xm   <= qrf_pkg::mag(opa);
          ym   <= qrf_pkg::mag(opb);
          prod <= '0;
          num  <= DL'(qrf_pkg::mag(opa)) << FRAC_BITS;
          rem  <= '0;
          q    <= '0;
          over <= 1'b0;
          cnt  <= (req.op == qrf_pkg::OP_DIV) ? CW'(DL) : CW'(3);
        end
      end
      qrf_pkg::A_MUL: begin
        prod <= (prod << 16) + (2*QW)'(pp);
        ym   <= ym << 16;
        cnt  <= cnt - CW'(1);
      end
      qrf_pkg::A_DIV: begin
        rem  <= ge ? rsub[QW-1:0] : rs[QW-1:0];
        q    <= {q[QW-2:0], ge};
        over <= over | q[QW-1];
        num  <= num << 1;
        cnt  <= cnt - CW'(1);
      end
      qrf_pkg::A_FIN: res <= fin;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/qrf_checker.sv
// Port-level checks for the quartic root finder, bound to the top level.
// Depends on qrf_pkg and quartic_root_finder_macros.svh.
`default_nettype none
`include "quartic_root_finder_macros.svh"

module qrf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [2:0] m_tuser,
  input wire logic       m_tlast
);

  `QRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `QRF_ASSERT_NEXT(a_one_run, s_tvalid && s_tready, !s_tready, "request taken during a run")
  `QRF_ASSERT_NOW(a_kind_range, m_tvalid, m_tuser <= 3'd5, "undefined result kind")
  `QRF_ASSERT_NOW(a_est_only, m_tvalid && !m_tlast, m_tuser == qrf_pkg::K_EST, "outcome before end")

endmodule

bind quartic_root_finder qrf_checker u_qrf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
